>>> rtl/core/bsrm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the buffer slot ring manager
// no dependencies; imported by every module of the block

package bsrm_pkg;

  localparam int SLOT_COUNT_DEF = 64;

  localparam int POS_W     = 6;   // slot index / position width
  localparam int LEN_W     = 7;   // ring length and fill count width
  localparam int MASK_W    = 64;  // used mask register width
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;  // widest register

  localparam logic [LEN_W-1:0] FILL_MAX = 7'd127;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USED_MASK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH = 1'b1;

  // request opcodes
  localparam logic [1:0] OP_TAKE    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;
  localparam logic [1:0] OP_COMMIT  = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [POS_W-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [POS_W-1:0] slot_out;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_end;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/bsrm_ctrl.sv
`timescale 1ns / 1ps
// control state machine: accept, skip scan, finish
// depends on bsrm_pkg

module bsrm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bsrm_pkg::dp_status_t stat,
  output bsrm_pkg::dp_cmd_t    cmd
);
  import bsrm_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_stall = !rst_n || (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.accept = in_valid && !in_stall;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = stat.need_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/bsrm_datapath.sv
`timescale 1ns / 1ps
// ring state, four-slot skip scanner and result register
// depends on bsrm_pkg; driven by bsrm_ctrl commands

module bsrm_datapath #(
  parameter int SLOT_COUNT = bsrm_pkg::SLOT_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bsrm_pkg::in_item_t                 in_data,
  input  bsrm_pkg::dp_cmd_t                  cmd,
  output bsrm_pkg::dp_status_t               stat,
  input  logic                               cfg_we,
  input  logic [bsrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsrm_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bsrm_pkg::out_item_t                out_data
);
  import bsrm_pkg::*;

  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int SCAN_LANES = 4;
  localparam logic [LEN_W-1:0] SLOT_LEN = LEN_W'(SLOT_COUNT);

  logic [MASK_W-1:0]     used_mask_r, used_mask_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;        // effective ring length
  logic [SLOT_COUNT-1:0] free_r, free_nxt;
  logic [POS_W-1:0]      head_r, head_nxt;
  logic [POS_W-1:0]      tail_r, tail_nxt;
  logic [LEN_W-1:0]      fill_r, fill_nxt;

  logic [1:0]            op_r, op_nxt;
  logic [POS_W-1:0]      idx_r, idx_nxt;
  logic [POS_W-1:0]      scan_pos_r, scan_pos_nxt;
  logic [LEN_W-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic                  hit_r, hit_nxt;
  logic [POS_W-1:0]      hit_pos_r, hit_pos_nxt;

  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [SLOT_COUNT-1:0] used_eff;
  logic [POS_W-1:0]      lane_pos [SCAN_LANES];
  logic [SCAN_LANES-1:0] lane_hit;
  logic                  hit_any;
  logic [POS_W-1:0]      hit_pos;
  logic                  pre_ok;
  logic [LEN_W-1:0]      cfg_len;

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p,
                                                input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] p1;
    p1 = {1'b0, p} + LEN_W'(1);
    return (p1 >= len) ? '0 : p1[POS_W-1:0];
  endfunction

  // a position beyond the ring counts as position zero
  function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W-1:0] p,
                                                input logic [LEN_W-1:0] len);
    return ({1'b0, p} >= len) ? '0 : p;
  endfunction

  assign used_eff = used_mask_r[SLOT_COUNT-1:0];

  // four consecutive ring positions per scan cycle
  always_comb begin
    lane_pos[0] = scan_pos_r;
    for (int j = 1; j < SCAN_LANES; j++) begin
      lane_pos[j] = next_pos(lane_pos[j-1], len_r);
    end
    for (int j = 0; j < SCAN_LANES; j++) begin
      lane_hit[j] = (({1'b0, scan_cnt_r} + (LEN_W+1)'(j)) < {1'b0, len_r})
                    && used_eff[lane_pos[j][IDX_W-1:0]];
    end
    hit_any = |lane_hit;
    hit_pos = '0;
    for (int j = SCAN_LANES - 1; j >= 0; j--) begin
      if (lane_hit[j]) begin
        hit_pos = lane_pos[j];
      end
    end
  end

  always_comb begin
    case (in_data.opcode)
      OP_TAKE: pre_ok = (fill_r != '0);
      OP_PEEK: pre_ok = (fill_r < len_r);
      default: pre_ok = 1'b1;
    endcase
  end

  assign stat.need_scan = pre_ok &&
                          (in_data.opcode == OP_TAKE || in_data.opcode == OP_PEEK);
  assign stat.scan_end  = hit_any ||
                          (({1'b0, scan_cnt_r} + (LEN_W+1)'(SCAN_LANES)) >= {1'b0, len_r});
  assign stat.out_free  = !out_valid_r || !out_stall;

  // ring length as written, clamped into 1..SLOT_COUNT
  always_comb begin
    if (cfg_wdata[LEN_W-1:0] == '0) begin
      cfg_len = LEN_W'(1);
    end else if (cfg_wdata[LEN_W-1:0] > SLOT_LEN) begin
      cfg_len = SLOT_LEN;
    end else begin
      cfg_len = cfg_wdata[LEN_W-1:0];
    end
  end

  always_comb begin
    used_mask_nxt = used_mask_r;
    len_nxt       = len_r;
    free_nxt      = free_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    scan_pos_nxt  = scan_pos_r;
    scan_cnt_nxt  = scan_cnt_r;
    hit_nxt       = hit_r;
    hit_pos_nxt   = hit_pos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.accept) begin
      op_nxt       = in_data.opcode;
      idx_nxt      = in_data.slot_index;
      hit_nxt      = 1'b0;
      scan_cnt_nxt = '0;
      scan_pos_nxt = (in_data.opcode == OP_TAKE) ? wrap_pos(head_r, len_r)
                                                 : wrap_pos(tail_r, len_r);
    end

    if (cmd.scan) begin
      if (hit_any) begin
        hit_nxt     = 1'b1;
        hit_pos_nxt = hit_pos;
      end else begin
        scan_pos_nxt = next_pos(lane_pos[SCAN_LANES-1], len_r);
        scan_cnt_nxt = scan_cnt_r + LEN_W'(SCAN_LANES);
      end
    end

    if (cmd.finish) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.status   = STATUS_REFUSED;
      out_data_nxt.slot_out = '0;
      case (op_r)
        OP_TAKE: begin
          if (hit_r) begin
            head_nxt = hit_pos_r;
            if (free_r[hit_pos_r[IDX_W-1:0]]) begin
              free_nxt[hit_pos_r[IDX_W-1:0]] = 1'b0;
              head_nxt              = next_pos(hit_pos_r, len_r);
              fill_nxt              = fill_r - LEN_W'(1);
              out_data_nxt.status   = STATUS_OK;
              out_data_nxt.slot_out = hit_pos_r;
            end
          end
        end
        OP_PEEK: begin
          if (hit_r) begin
            tail_nxt = hit_pos_r;
            if (free_r[hit_pos_r[IDX_W-1:0]]) begin
              out_data_nxt.status   = STATUS_OK;
              out_data_nxt.slot_out = hit_pos_r;
            end
          end
        end
        OP_RELEASE: begin
          if (({1'b0, idx_r} < SLOT_LEN) && !free_r[idx_r[IDX_W-1:0]]) begin
            free_nxt[idx_r[IDX_W-1:0]] = 1'b1;
            out_data_nxt.status        = STATUS_OK;
          end
        end
        default: begin
          // commit: no full check, count saturates
          tail_nxt            = next_pos(wrap_pos(tail_r, len_r), len_r);
          fill_nxt            = (fill_r < FILL_MAX) ? fill_r + LEN_W'(1) : fill_r;
          out_data_nxt.status = STATUS_OK;
        end
      endcase
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_USED_MASK: begin
          used_mask_nxt = cfg_wdata;
          free_nxt      = '1;
        end
        REG_RING_LENGTH: begin
          len_nxt = cfg_len;
        end
        default: begin
          len_nxt = len_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_mask_r <= '0;
      len_r       <= SLOT_LEN;
      free_r      <= '1;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_mask_r <= used_mask_nxt;
      len_r       <= len_nxt;
      free_r      <= free_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    scan_pos_r <= scan_pos_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    hit_pos_r  <= hit_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/buffer_slot_ring_manager.sv
`timescale 1ns / 1ps
// flow: release and commit, or a take/peek refused before the scan, go from accept
//   to the finish state, which waits for the output register to be free and loads
//   the result; take and peek first pass the scan state, skipping unused slots four per cycle
// throughput: one request at a time, a new one accepted the cycle after the result
//   is loaded; the output register lets a new request in while a result waits
// reset: synchronous; mask zero, ring length SLOT_COUNT, all slots free, no sweep

module buffer_slot_ring_manager #(
  parameter int SLOT_COUNT = bsrm_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bsrm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bsrm_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [bsrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsrm_pkg::CFG_W-1:0]     cfg_wdata
);
  import bsrm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  bsrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsrm_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/bsrm_checker.sv
`timescale 1ns / 1ps
// port-level checks for buffer_slot_ring_manager, bound to the top level
// depends on bsrm_pkg

module bsrm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input bsrm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input bsrm_pkg::out_item_t out_data
);
  import bsrm_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // refused requests never return a slot
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_REFUSED) |-> (out_data.slot_out == '0))
    else $error("refused result carries a slot");

  // one request in flight: the cycle after an accept is stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind buffer_slot_ring_manager bsrm_checker u_bsrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
